FILE: rtl/core/btmx_pkg.sv
package btmx_pkg;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture an accepted request
    logic walk;  // advance the walk by one trie level
  } btmx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reject;  // request at the port cannot be served (full or empty)
    logic last;    // walk sits on the lowest key bit
  } btmx_stat_t;

endpackage

FILE: rtl/core/btmx_ram.sv
module btmx_ram import btmx_pkg::*; #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/btmx_ctrl.sv
module btmx_ctrl import btmx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  btmx_stat_t stat,
  output btmx_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = stat.reject ? S_RESP : S_WALK;
        end
      end
      S_WALK: begin
        if (stat.last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.walk = (state == S_WALK);
  assign busy     = (state != S_IDLE);
  assign done     = (state == S_RESP);

endmodule

FILE: rtl/core/btmx_dpath.sv
module btmx_dpath import btmx_pkg::*; #(
  parameter int MAX_NODES = 8192,
  parameter int KEY_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  btmx_cmd_t           cmd,
  input  logic                req_type,
  input  logic [31:0]         key_value,
  output btmx_stat_t          stat,
  output logic [KEY_BITS-1:0] acc,
  output logic [1:0]          status
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int FULL_AT = MAX_NODES - KEY_BITS;

  logic [KEY_BITS-1:0] key;
  logic                req;
  logic [LVL_W-1:0]    level;
  logic [NODE_W-1:0]   cur;
  logic                fresh;
  logic                root_valid;
  logic [CNT_W-1:0]    nodes_used;
  logic                trie_empty;

  logic [2*NODE_W-1:0] rdata, links, wdata;
  logic [NODE_W-1:0]   lnk0, lnk1, child, alt, nxt, new_idx, raddr;
  logic                sel, miss, take, we, full;

  btmx_ram #(
    .WIDTH (2 * NODE_W),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cur),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // a node allocated in this walk, or the root before its first write, has no links
  assign links = (fresh || ((cur == '0) && !root_valid)) ? '0 : rdata;
  assign lnk0  = links[NODE_W-1:0];
  assign lnk1  = links[2*NODE_W-1:NODE_W];
  assign sel   = key[level];
  assign child = sel ? lnk1 : lnk0;
  assign alt   = sel ? lnk0 : lnk1;
  assign miss  = (child == '0);
  assign take  = miss ? ~sel : sel;
  assign new_idx = nodes_used[NODE_W-1:0];

  assign we    = cmd.walk && (req == REQ_INSERT) && miss;
  assign wdata = sel ? {new_idx, lnk0} : {lnk1, new_idx};

  always_comb begin
    if (req == REQ_INSERT) begin
      nxt = miss ? new_idx : child;
    end else begin
      nxt = miss ? alt : child;
    end
  end

  // follow the walk; outside it keep the root on the read port
  assign raddr = cmd.walk ? nxt : '0;

  assign full        = (nodes_used > CNT_W'(FULL_AT));
  assign stat.reject = (req_type == REQ_INSERT) ? full : trie_empty;
  assign stat.last   = (level == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key   <= key_value[KEY_BITS-1:0];
      req   <= req_type;
      level <= LVL_W'(KEY_BITS - 1);
      cur   <= '0;
      fresh <= 1'b0;
      acc   <= '0;
      if (!stat.reject) begin
        status <= ST_OK;
      end else if (req_type == REQ_INSERT) begin
        status <= ST_FULL;
      end else begin
        status <= ST_EMPTY;
      end
    end else if (cmd.walk) begin
      level <= level - 1'b1;
      cur   <= nxt;
      if (req == REQ_INSERT) begin
        fresh <= miss;
      end else begin
        acc <= KEY_BITS'({acc, take});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= CNT_W'(1);
      trie_empty <= 1'b1;
      root_valid <= 1'b0;
    end else begin
      if (we) begin
        nodes_used <= nodes_used + 1'b1;
        if (cur == '0) begin
          root_valid <= 1'b1;
        end
      end
      if (cmd.walk && stat.last && (req == REQ_INSERT)) begin
        trie_empty <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= CNT_W'(MAX_NODES))
    else $error("node count ran past the table");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && (req == REQ_QUERY)) |-> !we)
    else $error("query walk wrote the node table");

  a_empty_sticky: assert property (@(posedge clk) disable iff (rst)
    !trie_empty |=> !trie_empty)
    else $error("trie became empty again");
`endif

endmodule

FILE: rtl/core/binary_trie_min_xor_match.sv
// A served request gives its result once the walk has visited every key bit;
//   a refused insert or an empty-trie query gives it on the cycle after acceptance.
// Requests are served one at a time, busy high until the result beat is over, with
//   one node table read per trie level through the single read port.
// Reset (rst, synchronous): trie empty, root only in use; no clearing pass, as nodes are
//   zeroed on allocation. Results are strobed on done for one cycle; the receiver cannot stall.
module binary_trie_min_xor_match import btmx_pkg::*; #(
  parameter int MAX_NODES = 8192,
  parameter int KEY_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] key_value,
  output logic        done,
  output logic [31:0] match_value,
  output logic [1:0]  status
);

  // Command and status between the sequencer and the walk datapath.
  btmx_cmd_t           cmd;
  btmx_stat_t          stat;
  logic [KEY_BITS-1:0] acc;

  // Sequencer: idle, walk one level a cycle (skipped for a refused request), then present the beat for a cycle.
  btmx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: node table, node counter, walk registers and the result registers.
  btmx_dpath #(
    .MAX_NODES (MAX_NODES),
    .KEY_BITS  (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_type  (req_type),
    .key_value (key_value),
    .stat      (stat),
    .acc       (acc),
    .status    (status)
  );

  // Zero-extend the gathered path; it stays zero for inserts and errors.
  assign match_value = 32'(acc);

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("result beat not followed by idle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat while idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (match_value == '0))
    else $error("error result carries a match");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
    else $error("undefined status code");
`endif

endmodule

FILE: tb/tb_binary_trie_min_xor_match.sv
`timescale 1ns / 1ps

module tb_binary_trie_min_xor_match;
  import btmx_pkg::*;

  localparam int NODES = 8192;
  localparam int KBITS = 32;

  // One request waiting to go out. A set drain bit makes the sender hold
  // this beat back until every outstanding result has come home.
  typedef struct {
    logic        kind;
    logic [31:0] key;
    bit          drain;
  } trie_req_t;

  // One predicted result, tagged with the request kind for the tallies.
  typedef struct {
    logic        kind;
    logic [31:0] match;
    logic [1:0]  status;
  } trie_res_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        req_type = REQ_INSERT;
  logic [31:0] key_value = 32'h0;
  logic        busy;
  logic        done;
  logic [31:0] match_value;
  logic [1:0]  status;

  trie_req_t   req_backlog[$];
  trie_res_t   result_due[$];
  logic [31:0] gen_keys[$];     // keys offered for insertion, used to aim queries

  // Shadow of the node table: two child links per node, 0 meaning no child.
  int          kid_tbl [0:NODES-1][0:1];
  int          nodes_taken;
  bit          trie_bare;

  bit          beat_taken = 1'b0;
  int          gap_left = 0;
  int          sent = 0;
  int          total_beats = 0;
  int          fault_count = 0;
  int          n_insert_ok = 0;
  int          n_insert_full = 0;
  int          n_query_ok = 0;
  int          n_query_empty = 0;

  binary_trie_min_xor_match #(
    .MAX_NODES(NODES),
    .KEY_BITS (KBITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .key_value  (key_value),
    .done       (done),
    .match_value(match_value),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Insert a key into the shadow trie, allocating nodes from the bump count.
  // Refuse the whole insert, even of a stored key, when fewer than KBITS
  // free nodes remain.
  function automatic logic [1:0] trie_insert(logic [31:0] key);
    int   cur;
    int   nxt;
    int   lvl;
    logic b;
    if (NODES - nodes_taken < KBITS) return ST_FULL;
    cur = 0;
    for (lvl = KBITS - 1; lvl >= 0; lvl--) begin
      b   = key[lvl];
      nxt = kid_tbl[cur][b];
      if (nxt == 0) begin
        nxt = nodes_taken;
        nodes_taken++;
        kid_tbl[nxt][0] = 0;
        kid_tbl[nxt][1] = 0;
        kid_tbl[cur][b] = nxt;
      end
      cur = nxt;
    end
    trie_bare = 1'b0;
    return ST_OK;
  endfunction

  // Walk greedily from the top bit: follow the matching child where one
  // exists, else the other one. The path taken spells the nearest key.
  function automatic logic [1:0] trie_nearest(logic [31:0] key, output logic [31:0] hit);
    int   cur;
    int   nxt;
    int   lvl;
    logic b;
    hit = 32'h0;
    if (trie_bare) return ST_EMPTY;
    cur = 0;
    for (lvl = KBITS - 1; lvl >= 0; lvl--) begin
      b   = key[lvl];
      nxt = kid_tbl[cur][b];
      if (nxt == 0) begin
        b   = ~b;
        nxt = kid_tbl[cur][b];
      end
      hit = {hit[30:0], b};
      cur = (nxt < NODES) ? nxt : 0;
    end
    return ST_OK;
  endfunction

  task automatic queue_beat(logic kind, logic [31:0] key, bit drain);
    trie_req_t r;
    r.kind  = kind;
    r.key   = key;
    r.drain = drain;
    req_backlog.insert(req_backlog.size(), r);
  endtask

  function automatic logic [31:0] stored_key();
    return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
  endfunction

  // Perturb a key: one flipped bit, or a random spray over its low bits.
  function automatic logic [31:0] near_key(logic [31:0] base);
    if ($urandom_range(0, 1) == 0) return base ^ (32'h1 << $urandom_range(0, 31));
    return base ^ ($urandom & ((32'h1 << $urandom_range(1, 31)) - 32'h1));
  endfunction

  // Mix of inserts and queries. Inserts are mostly fresh keys, some close to
  // or equal to earlier ones; queries aim at stored keys, their neighbours,
  // or anywhere at all.
  task automatic mixed_beats(int count, int insert_pct);
    int          i;
    int          sel;
    logic [31:0] k;
    for (i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < insert_pct) begin
        if (sel < 60) k = $urandom;
        else if (sel < 85) k = near_key(stored_key());
        else k = stored_key();
        gen_keys.insert(gen_keys.size(), k);
        queue_beat(REQ_INSERT, k, 1'b0);
      end else begin
        if (sel < 40) k = stored_key();
        else if (sel < 80) k = near_key(stored_key());
        else k = $urandom;
        queue_beat(REQ_QUERY, k, 1'b0);
      end
    end
  endtask

  // Idle after a beat: a random gap after 30 percent of beats, none in every third
  // stretch of 150 beats, and none at all over the closing 200.
  function automatic int roll_gap();
    if (sent >= total_beats - 200) return 0;
    if ((sent / 150) % 3 == 2) return 0;
    if ($urandom_range(0, 99) < 30) return $urandom_range(1, 12);
    return 0;
  endfunction

  // Driver: change inputs on the falling edge only. Hold an offered beat until
  // an edge with busy low has taken it, then idle or offer the next one.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // hold the beat steady while the block is busy
    end else begin
      if (start) gap_left = roll_gap();
      if (gap_left > 0) begin
        gap_left--;
        start     <= 1'b0;
        req_type  <= 1'($urandom_range(0, 1));
        key_value <= $urandom;
      end else if (req_backlog.size() != 0 &&
                   !(req_backlog[0].drain && result_due.size() != 0)) begin
        start     <= 1'b1;
        req_type  <= req_backlog[0].kind;
        key_value <= req_backlog[0].key;
        void'(req_backlog.pop_front());
        sent++;
      end else begin
        // nothing to send, or draining: scribble on the idle payload
        start     <= 1'b0;
        req_type  <= 1'($urandom_range(0, 1));
        key_value <= $urandom;
      end
    end
  end

  // Monitor: sample on the rising edge. Check any result first, since it
  // always belongs to an earlier beat, then predict the beat taken here.
  always @(posedge clk) begin
    trie_res_t   exp_res;
    trie_res_t   got;
    logic [31:0] hit;
    beat_taken <= start && !busy && !rst;
    if (!rst) begin
      if (done) begin
        if (result_due.size() == 0) begin
          fault_count++;
          $display("%0t: result with nothing expected: match %h status %0d",
                   $time, match_value, status);
        end else begin
          exp_res = result_due.pop_front();
          if (match_value !== exp_res.match) begin
            fault_count++;
            $display("%0t: match_value mismatch: expected %h actual %h",
                     $time, exp_res.match, match_value);
          end
          if (status !== exp_res.status) begin
            fault_count++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_res.status, status);
          end
          if (exp_res.kind == REQ_INSERT) begin
            if (exp_res.status == ST_OK) n_insert_ok++;
            else n_insert_full++;
          end else begin
            if (exp_res.status == ST_OK) n_query_ok++;
            else n_query_empty++;
          end
        end
      end
      if (start && !busy) begin
        got.kind = req_type;
        if (req_type == REQ_INSERT) begin
          got.status = trie_insert(key_value);
          got.match  = 32'h0;
        end else begin
          got.status = trie_nearest(key_value, hit);
          got.match  = hit;
        end
        result_due.insert(result_due.size(), got);
      end
    end
  end

  // Watchdog: far beyond the slowest correct run of the whole sequence.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n;
    int idx;
    for (n = 0; n < NODES; n++) begin
      kid_tbl[n][0] = 0;
      kid_tbl[n][1] = 0;
    end
    nodes_taken = 1;
    trie_bare   = 1'b1;

    // Directed: queries on the empty trie, the extreme keys, duplicates,
    // alternating patterns and queries that force the walk to turn aside.
    queue_beat(REQ_QUERY,  32'h0000_0000, 1'b0);
    queue_beat(REQ_QUERY,  32'hFFFF_FFFF, 1'b0);
    queue_beat(REQ_INSERT, 32'h0000_0000, 1'b0);
    queue_beat(REQ_QUERY,  32'h0000_0000, 1'b0);
    queue_beat(REQ_QUERY,  32'hFFFF_FFFF, 1'b0);
    queue_beat(REQ_INSERT, 32'hFFFF_FFFF, 1'b0);
    queue_beat(REQ_INSERT, 32'h0000_0000, 1'b0);
    queue_beat(REQ_INSERT, 32'hFFFF_FFFF, 1'b0);
    queue_beat(REQ_QUERY,  32'h7FFF_FFFF, 1'b0);
    queue_beat(REQ_QUERY,  32'h8000_0000, 1'b0);
    queue_beat(REQ_INSERT, 32'h8000_0000, 1'b0);
    queue_beat(REQ_INSERT, 32'h0000_0001, 1'b0);
    queue_beat(REQ_INSERT, 32'hAAAA_AAAA, 1'b0);
    queue_beat(REQ_INSERT, 32'h5555_5555, 1'b0);
    queue_beat(REQ_QUERY,  32'h5555_5554, 1'b0);
    queue_beat(REQ_QUERY,  32'hAAAA_AAAB, 1'b0);
    queue_beat(REQ_QUERY,  32'h0000_0001, 1'b0);
    queue_beat(REQ_QUERY,  32'h8000_0001, 1'b0);
    queue_beat(REQ_QUERY,  32'h1234_5678, 1'b0);
    queue_beat(REQ_QUERY,  32'hC000_0000, 1'b0);
    gen_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                 32'hAAAA_AAAA, 32'h5555_5555};

    // Grow the trie with an insert-heavy mix.
    mixed_beats(600, 55);

    // Pause until the pipe is empty, then pour in fresh keys until the node
    // table runs out and inserts start being refused.
    idx = req_backlog.size();
    for (n = 0; n < 200; n++) begin
      gen_keys.insert(gen_keys.size(), $urandom);
      queue_beat(REQ_INSERT, gen_keys[gen_keys.size() - 1], 1'b0);
    end
    req_backlog[idx].drain = 1'b1;

    // Carry on against the full table: refused inserts, stored keys among
    // them, and queries over a dense trie.
    mixed_beats(430, 30);
    total_beats = req_backlog.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last beat to go, then for its result, then let the block
    // run on for longer than one walk to catch any stray strobe.
    while (req_backlog.size() != 0 || start) @(posedge clk);
    while (result_due.size() != 0) @(posedge clk);
    repeat (2 * KBITS + 8) @(posedge clk);

    $display("Ran %0d requests: %0d inserts stored, %0d refused on a full table,",
             total_beats, n_insert_ok, n_insert_full);
    $display("  %0d nearest-key queries answered, %0d on an empty trie, %0d nodes used",
             n_query_ok, n_query_empty, nodes_taken);
    if (fault_count == 0 && result_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
